@@ design/rgpg_pkg.sv @@
// Shared constants, types and arithmetic steps of the radial gradient pixel generator.
`timescale 1ns / 1ps
package rgpg_pkg;

  // Pixel coordinate format
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int POS_W      = COORD_BITS + FRAC_BITS;

  // Center and radius registers, Q12.4
  localparam int CTR_W = 16;
  localparam int RAD_W = 16;

  // |pixel - center| needs one bit above the wider of position and center magnitude
  localparam int DIFF_W = ((POS_W > CTR_W - 1) ? POS_W : CTR_W - 1) + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int D2_W   = SQ_W + 1;

  // Square root of d2 * 2^32 on the in-range path, d2 < r*r < 2^32
  localparam int RAD2_W     = 2 * RAD_W;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = ROOT_W + 4;
  localparam int SQ_STAGES  = 16;
  localparam int DIV_STAGES = 8;

  // Interpolation weight, Q0.16 with one meaning 65536
  localparam int T_W = 17;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  localparam int COLOR_W = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LEN  = 3'd4;

  // Item entering the root / divide pipeline
  typedef struct packed {
    logic              sat;
    logic [RAD2_W-1:0] d2;
  } root_in_t;

  // One restoring square root step: returns {remainder, root}
  function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(input logic [REM_W-1:0]  rem,
                                                        input logic [ROOT_W-1:0] root,
                                                        input logic [1:0]        pair);
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    sh    = {rem[REM_W-3:0], pair};
    trial = {2'b00, root, 2'b01};
    if (sh >= trial) begin
      return {sh - trial, root[ROOT_W-2:0], 1'b1};
    end else begin
      return {sh, root[ROOT_W-2:0], 1'b0};
    end
  endfunction

  // One restoring division step: returns {remainder, quotient bit}
  function automatic logic [RAD_W:0] div_step(input logic [RAD_W-1:0] rem,
                                              input logic [RAD_W-1:0] rad,
                                              input logic             nbit);
    logic [RAD_W:0] sh;
    logic [RAD_W:0] diff;
    sh   = {rem, nbit};
    diff = sh - {1'b0, rad};
    if (sh >= {1'b0, rad}) begin
      return {diff[RAD_W-1:0], 1'b1};
    end else begin
      return {sh[RAD_W-1:0], 1'b0};
    end
  endfunction

endpackage

@@ design/rgpg_root.sv @@
// Pipelined square root of d2*2^32 followed by division by the radius, giving t.
`timescale 1ns / 1ps
module rgpg_root (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  rgpg_pkg::root_in_t             in_data,
  output logic                           up_ready,
  input  logic [rgpg_pkg::RAD_W-1:0]     radius,
  output logic                           out_valid,
  output logic [rgpg_pkg::T_W-1:0]       out_t,
  input  logic                           dn_ready
);

  localparam int NSQ  = rgpg_pkg::SQ_STAGES;
  localparam int NDV  = rgpg_pkg::DIV_STAGES;
  localparam int NALL = NSQ + NDV;

  // Root stages: two bits of the root per stage
  logic                            sq_v_r    [1:NSQ];
  logic                            sq_sat_r  [1:NSQ];
  logic [rgpg_pkg::RAD2_W-1:0]     sq_d2_r   [1:NSQ];
  logic [rgpg_pkg::REM_W-1:0]      sq_rem_r  [1:NSQ];
  logic [rgpg_pkg::ROOT_W-1:0]     sq_root_r [1:NSQ];

  // Divide stages: two quotient bits per stage
  logic                            dv_v_r    [1:NDV];
  logic                            dv_sat_r  [1:NDV];
  logic [rgpg_pkg::RAD_W-1:0]      dv_rem_r  [1:NDV];
  logic [rgpg_pkg::RAD_W-1:0]      dv_low_r  [1:NDV];
  logic [rgpg_pkg::RAD_W-1:0]      dv_q_r    [1:NDV];

  // Load enables, collapsing bubbles; index NALL+1 is the consumer
  logic en [1:NALL+1];

  assign en[NALL+1] = dn_ready;

  genvar k;
  generate
    for (k = 1; k <= NSQ; k++) begin : g_sq_en
      assign en[k] = !sq_v_r[k] || en[k+1];
    end
    for (k = 1; k <= NDV; k++) begin : g_dv_en
      assign en[NSQ+k] = !dv_v_r[k] || en[NSQ+k+1];
    end
  endgenerate

  assign up_ready = en[1];

  // Square root stages
  generate
    for (k = 1; k <= NSQ; k++) begin : g_sq
      logic                            p_v;
      logic                            p_sat;
      logic [rgpg_pkg::RAD2_W-1:0]     p_d2;
      logic [rgpg_pkg::REM_W-1:0]      p_rem;
      logic [rgpg_pkg::ROOT_W-1:0]     p_root;
      logic [1:0]                      pair_hi;
      logic [1:0]                      pair_lo;
      logic [rgpg_pkg::REM_W+rgpg_pkg::ROOT_W-1:0] s1;
      logic [rgpg_pkg::REM_W+rgpg_pkg::ROOT_W-1:0] s2;

      if (k == 1) begin : g_first
        assign p_v    = in_valid;
        assign p_sat  = in_data.sat;
        assign p_d2   = in_data.d2;
        assign p_rem  = '0;
        assign p_root = '0;
      end else begin : g_next
        assign p_v    = sq_v_r[k-1];
        assign p_sat  = sq_sat_r[k-1];
        assign p_d2   = sq_d2_r[k-1];
        assign p_rem  = sq_rem_r[k-1];
        assign p_root = sq_root_r[k-1];
      end

      // Radicand is {d2, 32 zero bits}; only the first eight stages see d2 bits
      if (k <= NSQ / 2) begin : g_pairs
        assign pair_hi = p_d2[rgpg_pkg::RAD2_W-1-4*(k-1) -: 2];
        assign pair_lo = p_d2[rgpg_pkg::RAD2_W-3-4*(k-1) -: 2];
      end else begin : g_zero
        assign pair_hi = 2'b00;
        assign pair_lo = 2'b00;
      end

      assign s1 = rgpg_pkg::sqrt_step(p_rem, p_root, pair_hi);
      assign s2 = rgpg_pkg::sqrt_step(s1[rgpg_pkg::REM_W+rgpg_pkg::ROOT_W-1 -: rgpg_pkg::REM_W],
                                      s1[rgpg_pkg::ROOT_W-1:0], pair_lo);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[k] <= 1'b0;
        end else if (en[k]) begin
          sq_v_r[k] <= p_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          sq_sat_r[k]  <= p_sat;
          sq_d2_r[k]   <= p_d2;
          sq_rem_r[k]  <= s2[rgpg_pkg::REM_W+rgpg_pkg::ROOT_W-1 -: rgpg_pkg::REM_W];
          sq_root_r[k] <= s2[rgpg_pkg::ROOT_W-1:0];
        end
      end
    end
  endgenerate

  // Divide stages: root / radius; the high half of the root is below the radius
  generate
    for (k = 1; k <= NDV; k++) begin : g_dv
      logic                        p_v;
      logic                        p_sat;
      logic [rgpg_pkg::RAD_W-1:0]  p_rem;
      logic [rgpg_pkg::RAD_W-1:0]  p_low;
      logic [rgpg_pkg::RAD_W-1:0]  p_q;
      logic [rgpg_pkg::RAD_W:0]    d1;
      logic [rgpg_pkg::RAD_W:0]    d2;

      if (k == 1) begin : g_first
        assign p_v   = sq_v_r[NSQ];
        assign p_sat = sq_sat_r[NSQ];
        assign p_rem = sq_root_r[NSQ][rgpg_pkg::ROOT_W-1 -: rgpg_pkg::RAD_W];
        assign p_low = sq_root_r[NSQ][rgpg_pkg::RAD_W-1:0];
        assign p_q   = '0;
      end else begin : g_next
        assign p_v   = dv_v_r[k-1];
        assign p_sat = dv_sat_r[k-1];
        assign p_rem = dv_rem_r[k-1];
        assign p_low = dv_low_r[k-1];
        assign p_q   = dv_q_r[k-1];
      end

      assign d1 = rgpg_pkg::div_step(p_rem, radius, p_low[rgpg_pkg::RAD_W-1]);
      assign d2 = rgpg_pkg::div_step(d1[rgpg_pkg::RAD_W:1], radius, p_low[rgpg_pkg::RAD_W-2]);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_v_r[k] <= 1'b0;
        end else if (en[NSQ+k]) begin
          dv_v_r[k] <= p_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en[NSQ+k]) begin
          dv_sat_r[k] <= p_sat;
          dv_rem_r[k] <= d2[rgpg_pkg::RAD_W:1];
          dv_low_r[k] <= {p_low[rgpg_pkg::RAD_W-3:0], 2'b00};
          dv_q_r[k]   <= {p_q[rgpg_pkg::RAD_W-3:0], d1[0], d2[0]};
        end
      end
    end
  endgenerate

  // Out-of-range pixels take the full outer weight
  assign out_valid = dv_v_r[NDV];
  assign out_t     = dv_sat_r[NDV] ? rgpg_pkg::T_ONE : {1'b0, dv_q_r[NDV]};

endmodule

@@ design/radial_gradient_pixel_gen.sv @@
// Top level of the radial gradient pixel generator: config, distance, blend and output.
//
// Usage: write the five configuration registers through cfg_we / cfg_index /
// cfg_wdata while the block is idle (index 0 inner color, 1 outer color,
// 2 center x, 3 center y, 4 radius; other indexes are ignored). Then send
// pixel coordinates on the in_ channel; an item is taken when in_valid is
// high and in_stall is low. Each item yields one packed RGBA color on the
// out_ channel, taken when out_valid is high and out_stall is low.
// Each accepted item passes 29 register stages: 3 distance stages, 16 square
// root stages (two root bits each), 8 divide stages (two quotient bits each),
// a blend multiply stage and the output register.
// Throughput is one pixel per clock while out_stall is low. Every stage loads
// when it is empty or its successor moves, so bubbles close up; when the
// receiver stalls the pipeline fills and in_stall rises only once all stages
// hold items.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: inner opaque black, outer opaque white, center 0, radius 32 px.
// A radius of zero acts as the smallest radius.
`timescale 1ns / 1ps
module radial_gradient_pixel_gen (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rgpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgpg_pkg::COLOR_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rgpg_pkg::COORD_BITS-1:0]     in_pixel_x,
  input  logic [rgpg_pkg::COORD_BITS-1:0]     in_pixel_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rgpg_pkg::COLOR_W-1:0]        out_pixel_color
);

  localparam int DW1 = rgpg_pkg::DIFF_W + 1;
  localparam int PW  = 27;

  // Configuration registers
  logic [rgpg_pkg::COLOR_W-1:0] inner_r;
  logic [rgpg_pkg::COLOR_W-1:0] outer_r;
  logic [rgpg_pkg::CTR_W-1:0]   center_x_r;
  logic [rgpg_pkg::CTR_W-1:0]   center_y_r;
  logic [rgpg_pkg::RAD_W-1:0]   radius_r;
  logic [rgpg_pkg::RAD_W-1:0]   rad_eff;
  logic [rgpg_pkg::RAD2_W-1:0]  rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r    <= 32'h0000_00FF;
      outer_r    <= 32'hFFFF_FFFF;
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= 16'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgpg_pkg::CFG_INNER_COLOR: inner_r    <= cfg_wdata;
        rgpg_pkg::CFG_OUTER_COLOR: outer_r    <= cfg_wdata;
        rgpg_pkg::CFG_CENTER_X:    center_x_r <= cfg_wdata[rgpg_pkg::CTR_W-1:0];
        rgpg_pkg::CFG_CENTER_Y:    center_y_r <= cfg_wdata[rgpg_pkg::CTR_W-1:0];
        rgpg_pkg::CFG_RADIUS_LEN:  radius_r   <= cfg_wdata[rgpg_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero radius acts as one; r*r is held in a register since config is static
  assign rad_eff = (radius_r == '0) ? rgpg_pkg::RAD_W'(1) : radius_r;

  always_ff @(posedge clk) begin
    rr_r <= rad_eff * rad_eff;
  end

  // Pipeline valids and enables
  logic v_a_r, v_b_r, v_c_r, v_d_r, out_valid_r;
  logic en_a, en_b, en_c, en_d, en_e;
  logic root_ready;
  logic root_valid;
  logic [rgpg_pkg::T_W-1:0] root_t;

  assign en_e     = !out_valid_r || !out_stall;
  assign en_d     = !v_d_r || en_e;
  assign en_c     = !v_c_r || root_ready;
  assign en_b     = !v_b_r || en_c;
  assign en_a     = !v_a_r || en_b;
  assign in_stall = !en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) v_a_r <= in_valid;
      if (en_b) v_b_r <= v_a_r;
      if (en_c) v_c_r <= v_b_r;
      if (en_d) v_d_r <= root_valid;
      if (en_e) out_valid_r <= v_d_r;
    end
  end

  // Stage A: capture coordinates
  logic [rgpg_pkg::COORD_BITS-1:0] px_a_r, py_a_r;

  always_ff @(posedge clk) begin
    if (en_a) begin
      px_a_r <= in_pixel_x;
      py_a_r <= in_pixel_y;
    end
  end

  // Stage B: absolute offsets from the center, squared
  logic signed [DW1-1:0]          pos_x, pos_y, dx, dy;
  logic [rgpg_pkg::DIFF_W-1:0]    ax, ay;
  logic [rgpg_pkg::SQ_W-1:0]      sqx_b_r, sqy_b_r;

  always_comb begin
    pos_x = $signed(DW1'(px_a_r) << rgpg_pkg::FRAC_BITS);
    pos_y = $signed(DW1'(py_a_r) << rgpg_pkg::FRAC_BITS);
    dx    = pos_x - DW1'($signed(center_x_r));
    dy    = pos_y - DW1'($signed(center_y_r));
    ax    = dx[DW1-1] ? rgpg_pkg::DIFF_W'(-dx) : dx[rgpg_pkg::DIFF_W-1:0];
    ay    = dy[DW1-1] ? rgpg_pkg::DIFF_W'(-dy) : dy[rgpg_pkg::DIFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      sqx_b_r <= ax * ax;
      sqy_b_r <= ay * ay;
    end
  end

  // Stage C: squared distance and the at-or-beyond-radius test
  logic [rgpg_pkg::D2_W-1:0] d2_sum;
  rgpg_pkg::root_in_t        root_in_c_r;

  assign d2_sum = rgpg_pkg::D2_W'(sqx_b_r) + rgpg_pkg::D2_W'(sqy_b_r);

  always_ff @(posedge clk) begin
    if (en_c) begin
      root_in_c_r.sat <= (d2_sum >= rgpg_pkg::D2_W'(rr_r));
      root_in_c_r.d2  <= d2_sum[rgpg_pkg::RAD2_W-1:0];
    end
  end

  rgpg_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_c_r),
    .in_data   (root_in_c_r),
    .up_ready  (root_ready),
    .radius    (rad_eff),
    .out_valid (root_valid),
    .out_t     (root_t),
    .dn_ready  (en_d)
  );

  // Stage D: (outer - inner) * t per channel
  logic signed [PW-1:0]       prod_d_r [4];
  logic [rgpg_pkg::T_W-1:0]   t_d_r;

  always_ff @(posedge clk) begin
    if (en_d) begin
      t_d_r <= root_t;
      for (int c = 0; c < 4; c++) begin
        prod_d_r[c] <= ($signed({1'b0, outer_r[8*c +: 8]}) - $signed({1'b0, inner_r[8*c +: 8]}))
                       * $signed({1'b0, root_t});
      end
    end
  end

  // Stage E: inner*65536 + product, rounded, gives the channel byte
  logic signed [PW-1:0]          blend [4];
  logic [rgpg_pkg::COLOR_W-1:0]  color_nxt;
  logic [rgpg_pkg::COLOR_W-1:0]  color_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      blend[c] = $signed({3'b000, inner_r[8*c +: 8], 16'h0000}) + prod_d_r[c]
                 + PW'(32768);
      color_nxt[8*c +: 8] = blend[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      color_r <= color_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = color_r;

  // Input backpressure only when every top-level stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_a_r && v_b_r && v_c_r && v_d_r && out_valid_r))
    else $error("in_stall raised with an empty stage");

  // Weight never exceeds one
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    root_valid |-> (root_t <= rgpg_pkg::T_ONE))
    else $error("t above one");

  // Pixel at the center gives the inner color exactly
  a_center: assert property (@(posedge clk) disable iff (!rst_n)
    (v_d_r && en_e && t_d_r == '0) |=> (out_pixel_color == inner_r))
    else $error("center pixel differs from inner color");

  // Pixel at or past the radius gives the outer color exactly
  a_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (v_d_r && en_e && t_d_r == rgpg_pkg::T_ONE) |=> (out_pixel_color == outer_r))
    else $error("edge pixel differs from outer color");

endmodule

@@ verif/tb_radial_gradient_pixel_gen.sv @@
// Self-checking testbench for the radial gradient pixel generator.
`timescale 1ns / 1ps
module tb_radial_gradient_pixel_gen;

  // register indexes that map to no register
  localparam logic [rgpg_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [rgpg_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rgpg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rgpg_pkg::COLOR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rgpg_pkg::COORD_BITS-1:0] in_pixel_x = '0;
  logic [rgpg_pkg::COORD_BITS-1:0] in_pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rgpg_pkg::COLOR_W-1:0] out_pixel_color;

  radial_gradient_pixel_gen dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the gradient registers
  logic [31:0] sh_inner, sh_outer;
  logic signed [15:0] sh_cx, sh_cy;
  logic [15:0] sh_rad;

  logic [31:0] color_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 1'b0;

  // floor sqrt of a 64-bit value
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'h1_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // blended color for one pixel under the current registers
  function automatic logic [31:0] blend_color(logic [11:0] x, logic [11:0] y);
    longint signed px, py, ax, ay;
    longint unsigned d2, r, tt, a, b, c;
    logic [31:0] res;
    px = longint'(x) << 4;
    py = longint'(y) << 4;
    ax = px - sh_cx;
    ay = py - sh_cy;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    d2 = ax * ax + ay * ay;
    r = (sh_rad == 0) ? 1 : sh_rad;
    if (d2 >= r * r) tt = 65536;
    else begin
      tt = floor_root(d2 << 32) / r;
      if (tt > 65536) tt = 65536;
    end
    res = '0;
    for (int sh = 0; sh < 32; sh += 8) begin
      a = (sh_inner >> sh) & 8'hFF;
      b = (sh_outer >> sh) & 8'hFF;
      c = (a * (65536 - tt) + b * tt + 32768) >> 16;
      if (c > 255) c = 255;
      res[sh +: 8] = c[7:0];
    end
    return res;
  endfunction

  // one register write; cfg_we stays high until cfg_finish
  task automatic write_reg(logic [rgpg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    unique case (idx)
      rgpg_pkg::CFG_INNER_COLOR: sh_inner = val;
      rgpg_pkg::CFG_OUTER_COLOR: sh_outer = val;
      rgpg_pkg::CFG_CENTER_X: sh_cx = val[15:0];
      rgpg_pkg::CFG_CENTER_Y: sh_cy = val[15:0];
      rgpg_pkg::CFG_RADIUS_LEN: sh_rad = val[15:0];
      default: ;
    endcase
  endtask

  task automatic cfg_finish();
    cfg_we <= 1'b0;
  endtask

  // offer one pixel; hold it until taken
  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    color_q = {color_q, blend_color(x, y)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        $error("pixel_color: unexpected item, actual %h", out_pixel_color);
        errors++;
      end else begin
        if (out_pixel_color !== color_q[0]) begin
          $error("pixel_color: expected %h actual %h", color_q[0], out_pixel_color);
          errors++;
        end
        void'(color_q.pop_front());
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("radial_gradient_pixel_gen: mismatch");
      $finish;
    end
  end

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    bit known;
    logic [31:0] color;
  } pix_row_t;

  // directed pixels under reset registers (center 0, radius 32 px)
  pix_row_t dir_rows[] = '{
    '{12'd0, 12'd0, 1'b1, 32'h000000FF},
    '{12'd4095, 12'd4095, 1'b1, 32'hFFFFFFFF},
    '{12'd32, 12'd0, 1'b1, 32'hFFFFFFFF},
    '{12'd0, 12'd32, 1'b1, 32'hFFFFFFFF},
    '{12'd4095, 12'd0, 1'b1, 32'hFFFFFFFF},
    '{12'd0, 12'd4095, 1'b1, 32'hFFFFFFFF},
    '{12'd31, 12'd0, 1'b0, 32'h0},
    '{12'd16, 12'd16, 1'b0, 32'h0},
    '{12'd1, 12'd0, 1'b0, 32'h0},
    '{12'd22, 12'd23, 1'b0, 32'h0},
    '{12'd2730, 12'd1365, 1'b1, 32'hFFFFFFFF}
  };

  task automatic random_cfg(bit extreme);
    write_reg(rgpg_pkg::CFG_INNER_COLOR, $urandom());
    write_reg(rgpg_pkg::CFG_OUTER_COLOR, $urandom());
    if (extreme) begin
      write_reg(rgpg_pkg::CFG_CENTER_X, $urandom_range(1) ? 32'h7FFF : 32'h8000);
      write_reg(rgpg_pkg::CFG_CENTER_Y, $urandom_range(1) ? 32'hFFFF : 32'h8000);
      write_reg(rgpg_pkg::CFG_RADIUS_LEN, $urandom_range(1) ? 32'hFFFF : 32'h0001);
    end else begin
      write_reg(rgpg_pkg::CFG_CENTER_X, $urandom_range(65535));
      write_reg(rgpg_pkg::CFG_CENTER_Y, $urandom_range(65535));
      write_reg(rgpg_pkg::CFG_RADIUS_LEN, $urandom_range(1, 65535));
    end
    cfg_finish();
  endtask

  // pixel near the center so t covers the whole range, or one in four anywhere
  task automatic random_pixel();
    int cx, cy, span;
    cx = int'(sh_cx) >>> 4;
    cy = int'(sh_cy) >>> 4;
    span = (sh_rad >> 4) + 2;
    if ($urandom_range(3) == 0) send_pixel(12'($urandom()), 12'($urandom()));
    else send_pixel(12'(cx + $urandom_range(2 * span) - span),
                    12'(cy + $urandom_range(2 * span) - span));
  endtask

  initial begin
    sh_inner = 32'h000000FF;
    sh_outer = 32'hFFFFFFFF;
    sh_cx = '0;
    sh_cy = '0;
    sh_rad = 16'd512;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known &&
          blend_color(dir_rows[i].x, dir_rows[i].y) != dir_rows[i].color) begin
        $error("pixel_color: row %0d expected %h actual %h", i, dir_rows[i].color,
               blend_color(dir_rows[i].x, dir_rows[i].y));
        errors++;
      end
      send_pixel(dir_rows[i].x, dir_rows[i].y);
    end
    drain();
    // zero radius acts as one, unknown indexes ignored
    write_reg(rgpg_pkg::CFG_RADIUS_LEN, 32'h0);
    write_reg(CFG_SPARE_HI, 32'h1234);
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(rgpg_pkg::CFG_CENTER_X, 32'h0010);
    write_reg(rgpg_pkg::CFG_CENTER_Y, 32'h0020);
    cfg_finish();
    send_pixel(12'd1, 12'd2);
    send_pixel(12'd2, 12'd2);
    drain();

    // random phases with changing idle patterns
    for (int ph = 0; ph < 7; ph++) begin
      send_idle = (ph < 2) ? 35 : (ph < 4) ? 83 : 0;
      recv_idle = (ph < 2) ? 83 : (ph < 4) ? 35 : 0;
      random_cfg(ph == 1 || ph == 5);
      if (ph == 4) begin
        fork
          begin
            hold_recv = 1'b1;
            repeat (80) @(posedge clk);
            hold_recv = 1'b0;
          end
        join_none
      end
      repeat (150) random_pixel();
      drain();
    end

    if (errors == 0 && color_q.size() == 0) begin
      $display("radial_gradient_pixel_gen: match");
    end else begin
      $display("radial_gradient_pixel_gen: mismatch");
    end
    $finish;
  end
endmodule
